/* sv/bfvr_pkg.sv */
// ----------------------------------------------------------------------------
// bfvr_pkg
// types and constants shared by the boundary face vertex reindex block
// ----------------------------------------------------------------------------
`default_nettype none

package bfvr_pkg;

    localparam int VIDX_W            = 12;
    localparam int VCNT_W            = 13;
    localparam int FCNT_W            = 14;
    localparam int BCNT_W            = 15;
    localparam int MAX_MESH_VERTICES = 4096;
    localparam int MAP_AW            = $clog2(MAX_MESH_VERTICES);
    localparam int EPOCH_W           = 4;
    localparam int MAP_W             = EPOCH_W + VIDX_W;

    localparam logic [1:0] INTERIOR_SHARERS = 2'd2;

    typedef logic [MAP_AW-1:0]  t_maddr;
    typedef logic [MAP_W-1:0]   t_mword;
    typedef logic [EPOCH_W-1:0] t_epoch;
    typedef logic [VIDX_W-1:0]  t_vidx;

    typedef enum logic [1:0] {
        LANE_A,
        LANE_B,
        LANE_C
    } t_lane;

    typedef struct packed {
        logic  accept;
        t_lane rd_sel;
        logic  res_en;
        t_lane res_lane;
        logic  clr_en;
        logic  clr_done;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic wrap_need;
        logic boundary;
    } t_stat;

endpackage

`default_nettype wire

/* sv/bfvr_ram.sv */
// ----------------------------------------------------------------------------
// bfvr_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bfvr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sv/bfvr_ctrl.sv */
// ----------------------------------------------------------------------------
// bfvr_ctrl
// sequencer for map clearing, per-vertex lookups and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module bfvr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire bfvr_pkg::t_stat i_stat,
    output bfvr_pkg::t_cmd       o_cmd
);

    import bfvr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RES_A,
        S_RES_B,
        S_RES_C,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   pend;
    logic   can_take;
    logic   accept;
    logic   wrap_go;
    t_cmd   cmd;

    always_comb begin
        out_free = !r_out_valid || !i_stall;
        pend     = (r_state == S_RES_C) || (r_state == S_HOLD);
        can_take = (r_state == S_IDLE) || (pend && out_free);
        o_stall  = !(can_take && !i_stat.wrap_need);
        accept   = i_valid && !o_stall;
        wrap_go  = can_take && i_valid && i_stat.wrap_need;

        cmd          = '0;
        cmd.accept   = accept;
        cmd.rd_sel   = LANE_A;
        cmd.res_lane = LANE_A;
        cmd.out_load = pend && out_free;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_en   = 1'b1;
                cmd.clr_done = i_stat.clr_last;
            end
            S_RES_A: begin
                cmd.rd_sel   = LANE_B;
                cmd.res_en   = 1'b1;
                cmd.res_lane = LANE_A;
            end
            S_RES_B: begin
                cmd.rd_sel   = LANE_C;
                cmd.res_en   = 1'b1;
                cmd.res_lane = LANE_B;
            end
            S_RES_C: begin
                cmd.res_en   = 1'b1;
                cmd.res_lane = LANE_C;
            end
            S_IDLE, S_HOLD: begin
            end
            default: begin
            end
        endcase

        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_RES_A: n_state = S_RES_B;
            S_RES_B: n_state = S_RES_C;
            S_IDLE, S_RES_C, S_HOLD: begin
                priority if (pend && !out_free) begin
                    n_state = S_HOLD;
                end else if (accept) begin
                    n_state = i_stat.boundary ? S_RES_A : S_HOLD;
                end else if (wrap_go) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        priority if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_clr_and_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clr_en && cmd.res_en))
        else $error("map clear overlaps a lookup");

    a_bnd_starts_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept && i_stat.boundary |=> cmd.res_en && (cmd.res_lane == LANE_A))
        else $error("boundary face did not start with vertex a");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result overwrites a held request");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_en |-> !cmd.accept)
        else $error("request accepted during map clear");
`endif

endmodule

`default_nettype wire

/* sv/bfvr_dp.sv */
// ----------------------------------------------------------------------------
// bfvr_dp
// vertex map, epoch tags, counters and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module bfvr_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire bfvr_pkg::t_cmd          i_cmd,
    output bfvr_pkg::t_stat              o_stat,
    input  wire logic                    i_new_mesh,
    input  wire logic [1:0]              i_sharer_count,
    input  wire logic [bfvr_pkg::VIDX_W-1:0] i_vert_a,
    input  wire logic [bfvr_pkg::VIDX_W-1:0] i_vert_b,
    input  wire logic [bfvr_pkg::VIDX_W-1:0] i_vert_c,
    output logic                         o_is_boundary,
    output logic [bfvr_pkg::FCNT_W-1:0]  o_source_face,
    output logic [bfvr_pkg::VIDX_W-1:0]  o_surf_a,
    output logic [bfvr_pkg::VIDX_W-1:0]  o_surf_b,
    output logic [bfvr_pkg::VIDX_W-1:0]  o_surf_c,
    output logic [2:0]                   o_new_mask,
    output logic [bfvr_pkg::VCNT_W-1:0]  o_surface_vertex_total,
    output logic [bfvr_pkg::BCNT_W-1:0]  o_boundary_face_total
);

    import bfvr_pkg::*;

    t_maddr              r_vert_a, r_vert_b, r_vert_c;
    logic                r_is_bnd;
    logic [FCNT_W-1:0]   r_src_face;
    logic [BCNT_W-1:0]   r_btot;
    logic [VCNT_W-1:0]   r_vcnt, n_vcnt;
    logic [FCNT_W-1:0]   r_fcnt;
    logic [BCNT_W-1:0]   r_bcnt;
    t_epoch              r_epoch;
    t_maddr              r_clr_addr;
    logic                r_byp_hit;
    t_mword              r_byp_data;
    t_vidx               r_surf_a, r_surf_b, r_surf_c;
    t_vidx               n_surf_a, n_surf_b, n_surf_c;
    logic [2:0]          r_mask, n_mask;

    logic                r_out_bnd;
    logic [FCNT_W-1:0]   r_out_src;
    t_vidx               r_out_a, r_out_b, r_out_c;
    logic [2:0]          r_out_mask;
    logic [VCNT_W-1:0]   r_out_vtot;
    logic [BCNT_W-1:0]   r_out_btot;

    t_maddr              rd_addr;
    t_maddr              wr_addr;
    t_maddr              lane_addr;
    t_mword              wr_data;
    t_mword              ram_q;
    t_mword              rd_word;
    logic                wr_en;
    logic                hit;
    logic                res_new;
    t_vidx               res_num;
    logic [VCNT_W-1:0]   vcnt_step;
    logic                clr_cnt;
    logic                bnd_in;
    logic [FCNT_W-1:0]   fbase;
    logic [BCNT_W-1:0]   bnext;

    bfvr_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAX_MESH_VERTICES)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        bnd_in  = (i_sharer_count != INTERIOR_SHARERS);
        clr_cnt = i_cmd.accept && i_new_mesh;
        fbase   = clr_cnt ? '0 : r_fcnt;
        bnext   = (clr_cnt ? '0 : r_bcnt) + BCNT_W'(bnd_in);

        unique case (i_cmd.rd_sel)
            LANE_A:  rd_addr = i_vert_a[MAP_AW-1:0];
            LANE_B:  rd_addr = r_vert_b;
            LANE_C:  rd_addr = r_vert_c;
            default: rd_addr = i_vert_a[MAP_AW-1:0];
        endcase

        unique case (i_cmd.res_lane)
            LANE_A:  lane_addr = r_vert_a;
            LANE_B:  lane_addr = r_vert_b;
            LANE_C:  lane_addr = r_vert_c;
            default: lane_addr = r_vert_a;
        endcase

        // write-to-read collision in the same cycle takes the written word
        rd_word = r_byp_hit ? r_byp_data : ram_q;
        hit     = (rd_word[MAP_W-1 -: EPOCH_W] == r_epoch);
        res_new = i_cmd.res_en && !hit;
        res_num = hit ? rd_word[VIDX_W-1:0] : r_vcnt[VIDX_W-1:0];

        wr_en   = i_cmd.clr_en || res_new;
        wr_addr = i_cmd.clr_en ? r_clr_addr : lane_addr;
        wr_data = i_cmd.clr_en ? '0 : {r_epoch, res_num};

        vcnt_step = r_vcnt + VCNT_W'(res_new);
        n_vcnt    = clr_cnt ? '0 : vcnt_step;

        n_surf_a = r_surf_a;
        n_surf_b = r_surf_b;
        n_surf_c = r_surf_c;
        n_mask   = r_mask;
        if (i_cmd.res_en) begin
            unique case (i_cmd.res_lane)
                LANE_A: begin
                    n_surf_a  = res_num;
                    n_mask[0] = res_new;
                end
                LANE_B: begin
                    n_surf_b  = res_num;
                    n_mask[1] = res_new;
                end
                LANE_C: begin
                    n_surf_c  = res_num;
                    n_mask[2] = res_new;
                end
                default: begin
                end
            endcase
        end

        o_stat.clr_last  = (r_clr_addr == '1);
        o_stat.wrap_need = i_new_mesh && (r_epoch == '1);
        o_stat.boundary  = bnd_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt     <= '0;
            r_fcnt     <= '0;
            r_bcnt     <= '0;
            r_epoch    <= '0;
            r_clr_addr <= '0;
            r_byp_hit  <= 1'b0;
        end else begin
            r_vcnt    <= n_vcnt;
            r_byp_hit <= wr_en && (wr_addr == rd_addr);
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            priority if (i_cmd.clr_done) begin
                r_epoch <= EPOCH_W'(1);
            end else if (clr_cnt) begin
                r_epoch <= r_epoch + 1'b1;
            end
            if (i_cmd.accept) begin
                r_fcnt <= fbase + 1'b1;
                r_bcnt <= bnext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_data;
        r_surf_a   <= n_surf_a;
        r_surf_b   <= n_surf_b;
        r_surf_c   <= n_surf_c;
        r_mask     <= n_mask;
        if (i_cmd.accept) begin
            r_vert_a   <= i_vert_a[MAP_AW-1:0];
            r_vert_b   <= i_vert_b[MAP_AW-1:0];
            r_vert_c   <= i_vert_c[MAP_AW-1:0];
            r_is_bnd   <= bnd_in;
            r_src_face <= fbase;
            r_btot     <= bnext;
        end
        if (i_cmd.out_load) begin
            r_out_bnd  <= r_is_bnd;
            r_out_src  <= r_src_face;
            r_out_a    <= r_is_bnd ? n_surf_a : '0;
            r_out_b    <= r_is_bnd ? n_surf_b : '0;
            r_out_c    <= r_is_bnd ? n_surf_c : '0;
            r_out_mask <= r_is_bnd ? n_mask : '0;
            r_out_vtot <= vcnt_step;
            r_out_btot <= r_btot;
        end
    end

    assign o_is_boundary          = r_out_bnd;
    assign o_source_face          = r_out_src;
    assign o_surf_a               = r_out_a;
    assign o_surf_b               = r_out_b;
    assign o_surf_c               = r_out_c;
    assign o_new_mask             = r_out_mask;
    assign o_surface_vertex_total = r_out_vtot;
    assign o_boundary_face_total  = r_out_btot;

endmodule

`default_nettype wire

/* sv/boundary_face_vertex_reindex.sv */
// boundary face: the three map lookups go in turn through the single read port of
//   the vertex map, then the result is registered; the next face can be taken in
//   the last lookup state; interior faces every cycle while output is not stalled
// reset: a clearing pass over all 4096 map entries, no request taken meanwhile;
//   a new-mesh face that exhausts the 4-bit epoch tag runs the same pass first
// ----------------------------------------------------------------------------
// boundary_face_vertex_reindex
// keeps boundary faces of a tetrahedral mesh and renumbers their vertices
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_face_vertex_reindex (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_new_mesh,
    input  wire logic [1:0]                   i_sharer_count,
    input  wire logic [bfvr_pkg::VIDX_W-1:0]  i_vert_a,
    input  wire logic [bfvr_pkg::VIDX_W-1:0]  i_vert_b,
    input  wire logic [bfvr_pkg::VIDX_W-1:0]  i_vert_c,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_is_boundary,
    output logic [bfvr_pkg::FCNT_W-1:0]       o_source_face,
    output logic [bfvr_pkg::VIDX_W-1:0]       o_surf_a,
    output logic [bfvr_pkg::VIDX_W-1:0]       o_surf_b,
    output logic [bfvr_pkg::VIDX_W-1:0]       o_surf_c,
    output logic [2:0]                        o_new_mask,
    output logic [bfvr_pkg::VCNT_W-1:0]       o_surface_vertex_total,
    output logic [bfvr_pkg::BCNT_W-1:0]       o_boundary_face_total
);

    import bfvr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bfvr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bfvr_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_stat                 (stat),
        .i_new_mesh             (i_new_mesh),
        .i_sharer_count         (i_sharer_count),
        .i_vert_a               (i_vert_a),
        .i_vert_b               (i_vert_b),
        .i_vert_c               (i_vert_c),
        .o_is_boundary          (o_is_boundary),
        .o_source_face          (o_source_face),
        .o_surf_a               (o_surf_a),
        .o_surf_b               (o_surf_b),
        .o_surf_c               (o_surf_c),
        .o_new_mask             (o_new_mask),
        .o_surface_vertex_total (o_surface_vertex_total),
        .o_boundary_face_total  (o_boundary_face_total)
    );

endmodule

`default_nettype wire

/* bench/bfvr_reindex_checker.sv */
// ----------------------------------------------------------------------------
// bfvr_reindex_checker
// Watches the request and result channels of the boundary face vertex reindex
// block. Every accepted request is run through a local copy of the vertex map
// and the counters, and the predicted result is queued. Every accepted result
// is compared field by field against the oldest queued prediction. The
// mismatch count and the number of outstanding predictions go back to the
// testbench top.
// ----------------------------------------------------------------------------
module bfvr_reindex_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic                          i_new_mesh,
    input  logic [1:0]                    i_sharer_count,
    input  bfvr_pkg::t_vidx               i_vert_a,
    input  bfvr_pkg::t_vidx               i_vert_b,
    input  bfvr_pkg::t_vidx               i_vert_c,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic                          i_is_boundary,
    input  logic [bfvr_pkg::FCNT_W-1:0]   i_source_face,
    input  bfvr_pkg::t_vidx               i_surf_a,
    input  bfvr_pkg::t_vidx               i_surf_b,
    input  bfvr_pkg::t_vidx               i_surf_c,
    input  logic [2:0]                    i_new_mask,
    input  logic [bfvr_pkg::VCNT_W-1:0]   i_surface_vertex_total,
    input  logic [bfvr_pkg::BCNT_W-1:0]   i_boundary_face_total,
    output int                            o_fail_count,
    output int                            o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import bfvr_pkg::*;

    typedef struct {
        logic                is_boundary;
        logic [FCNT_W-1:0]   source_face;
        t_vidx               surf [3];
        logic [2:0]          new_mask;
        logic [VCNT_W-1:0]   vertex_total;
        logic [BCNT_W-1:0]   face_total;
    } t_face_result;

    bit                  seen_vertex [MAX_MESH_VERTICES];
    t_vidx               surface_num [MAX_MESH_VERTICES];
    logic [VCNT_W-1:0]   surface_count = '0;
    logic [FCNT_W-1:0]   face_count    = '0;
    logic [BCNT_W-1:0]   kept_count    = '0;
    t_face_result        expected_faces [$];
    int                  fails = 0;

    initial begin
        foreach (seen_vertex[v]) seen_vertex[v] = 1'b0;
    end

    function automatic void clear_mesh();
        foreach (seen_vertex[v]) seen_vertex[v] = 1'b0;
        surface_count = '0;
        face_count    = '0;
        kept_count    = '0;
    endfunction

    function automatic t_face_result reindex_face(input logic nm, input logic [1:0] sharers,
                                                  input t_vidx va, input t_vidx vb,
                                                  input t_vidx vc);
        t_face_result r;
        t_vidx        verts [3];
        verts[0] = va;
        verts[1] = vb;
        verts[2] = vc;
        if (nm) clear_mesh();
        r.is_boundary = 1'b0;
        r.source_face = face_count;
        r.new_mask    = 3'b000;
        foreach (r.surf[j]) r.surf[j] = '0;
        face_count = face_count + 1'b1;
        if (sharers != INTERIOR_SHARERS) begin
            r.is_boundary = 1'b1;
            for (int j = 0; j < 3; j++) begin
                if (seen_vertex[verts[j]]) begin
                    r.surf[j] = surface_num[verts[j]];
                end else begin
                    r.surf[j]               = surface_count[VIDX_W-1:0];
                    seen_vertex[verts[j]]   = 1'b1;
                    surface_num[verts[j]]   = surface_count[VIDX_W-1:0];
                    surface_count           = surface_count + 1'b1;
                    r.new_mask[j]           = 1'b1;
                end
            end
            kept_count = kept_count + 1'b1;
        end
        r.vertex_total = surface_count;
        r.face_total   = kept_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            fails++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_face_result want;
        if (!i_rst_n) begin
            clear_mesh();
            expected_faces.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                expected_faces.insert(expected_faces.size(),
                                      reindex_face(i_new_mesh, i_sharer_count,
                                                   i_vert_a, i_vert_b, i_vert_c));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_faces.size() == 0) begin
                    fails++;
                    $error("result with no request outstanding");
                end else begin
                    want = expected_faces.pop_front();
                    check_field("is_boundary", want.is_boundary, i_is_boundary);
                    check_field("source_face", want.source_face, i_source_face);
                    check_field("surf_a", want.surf[0], i_surf_a);
                    check_field("surf_b", want.surf[1], i_surf_b);
                    check_field("surf_c", want.surf[2], i_surf_c);
                    check_field("new_mask", want.new_mask, i_new_mask);
                    check_field("surface_vertex_total", want.vertex_total,
                                i_surface_vertex_total);
                    check_field("boundary_face_total", want.face_total,
                                i_boundary_face_total);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_faces.size();
    end

endmodule

/* bench/tb_boundary_face_vertex_reindex.sv */
// ----------------------------------------------------------------------------
// tb_boundary_face_vertex_reindex
// Drives faces into the boundary face vertex reindex block: a short directed
// set covering field extremes, interior and boundary faces, every sharer count
// and repeated vertices, then random meshes drawn from small vertex pools with
// some unstructured noise, under three sender/receiver idling mixes. A checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_boundary_face_vertex_reindex;

    timeunit 1ns;
    timeprecision 1ps;

    import bfvr_pkg::*;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                i_new_mesh     = 1'b0;
    logic [1:0]          i_sharer_count = '0;
    t_vidx               i_vert_a       = '0;
    t_vidx               i_vert_b       = '0;
    t_vidx               i_vert_c       = '0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_is_boundary;
    logic [FCNT_W-1:0]   o_source_face;
    t_vidx               o_surf_a;
    t_vidx               o_surf_b;
    t_vidx               o_surf_c;
    logic [2:0]          o_new_mask;
    logic [VCNT_W-1:0]   o_surface_vertex_total;
    logic [BCNT_W-1:0]   o_boundary_face_total;

    int                  fail_count;
    int                  pending;
    int                  sender_idle_pct = 0;
    int                  receiver_stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    boundary_face_vertex_reindex i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_new_mesh             (i_new_mesh),
        .i_sharer_count         (i_sharer_count),
        .i_vert_a               (i_vert_a),
        .i_vert_b               (i_vert_b),
        .i_vert_c               (i_vert_c),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_is_boundary          (o_is_boundary),
        .o_source_face          (o_source_face),
        .o_surf_a               (o_surf_a),
        .o_surf_b               (o_surf_b),
        .o_surf_c               (o_surf_c),
        .o_new_mask             (o_new_mask),
        .o_surface_vertex_total (o_surface_vertex_total),
        .o_boundary_face_total  (o_boundary_face_total)
    );

    bfvr_reindex_checker i_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_req_valid            (i_valid),
        .i_req_stall            (o_stall),
        .i_new_mesh             (i_new_mesh),
        .i_sharer_count         (i_sharer_count),
        .i_vert_a               (i_vert_a),
        .i_vert_b               (i_vert_b),
        .i_vert_c               (i_vert_c),
        .i_rsp_valid            (o_valid),
        .i_rsp_stall            (i_stall),
        .i_is_boundary          (o_is_boundary),
        .i_source_face          (o_source_face),
        .i_surf_a               (o_surf_a),
        .i_surf_b               (o_surf_b),
        .i_surf_c               (o_surf_c),
        .i_new_mask             (o_new_mask),
        .i_surface_vertex_total (o_surface_vertex_total),
        .i_boundary_face_total  (o_boundary_face_total),
        .o_fail_count           (fail_count),
        .o_pending              (pending)
    );

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    task automatic send_face(input logic nm, input logic [1:0] sharers,
                             input t_vidx va, input t_vidx vb, input t_vidx vc);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_new_mesh     <= nm;
        i_sharer_count <= sharers;
        i_vert_a       <= va;
        i_vert_b       <= vb;
        i_vert_c       <= vc;
        do @(posedge i_clk); while (o_stall);
    endtask

    // mostly meshes over a small vertex pool so that vertices are shared,
    // with some faces that are fully random
    task automatic random_meshes(input int n_faces);
        int          sent;
        int          mesh_len;
        int          span;
        int          roll;
        t_vidx       base;
        logic [1:0]  sharers;
        sent = 0;
        while (sent < n_faces) begin
            mesh_len = $urandom_range(4, 48);
            span     = $urandom_range(2, 40);
            base     = t_vidx'($urandom_range(0, 4095));
            for (int k = 0; k < mesh_len && sent < n_faces; k++) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_face($urandom_range(0, 99) < 15, 2'($urandom_range(0, 3)),
                              t_vidx'($urandom_range(0, 4095)),
                              t_vidx'($urandom_range(0, 4095)),
                              t_vidx'($urandom_range(0, 4095)));
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55)      sharers = INTERIOR_SHARERS;
                    else if (roll < 85) sharers = 2'd1;
                    else if (roll < 93) sharers = 2'd0;
                    else                sharers = 2'd3;
                    send_face(k == 0, sharers,
                              base + t_vidx'($urandom_range(0, span)),
                              base + t_vidx'($urandom_range(0, span)),
                              base + t_vidx'($urandom_range(0, span)));
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct    = 28;
        receiver_stall_pct = 71;
        send_face(1'b1, 2'd1, 12'd0,     12'd0,     12'd0);
        send_face(1'b0, 2'd1, 12'd4095,  12'd0,     12'd4095);
        send_face(1'b0, 2'd1, 12'hAAA,   12'h555,   12'h555);
        send_face(1'b0, INTERIOR_SHARERS, 12'd1, 12'd2, 12'd3);
        send_face(1'b0, 2'd0, 12'd1,     12'd2,     12'd3);
        send_face(1'b0, 2'd3, 12'd3,     12'd2,     12'd1);
        send_face(1'b0, INTERIOR_SHARERS, 12'd4095, 12'd4095, 12'd4095);
        send_face(1'b1, INTERIOR_SHARERS, 12'd7, 12'd8, 12'd9);
        send_face(1'b0, 2'd1, 12'd7,     12'd7,     12'd9);
        send_face(1'b1, 2'd0, 12'd4095,  12'd4094,  12'd4093);
        send_face(1'b0, 2'd3, 12'd4093,  12'd4095,  12'd10);
        send_face(1'b0, 2'd1, 12'hFFF,   12'hAAA,   12'h555);
        random_meshes(200);

        sender_idle_pct    = 71;
        receiver_stall_pct = 28;
        random_meshes(200);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        random_meshes(200);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/bfvr_pkg.sv
sv/bfvr_ram.sv
sv/bfvr_ctrl.sv
sv/bfvr_dp.sv
sv/boundary_face_vertex_reindex.sv
bench/bfvr_reindex_checker.sv
bench/tb_boundary_face_vertex_reindex.sv
